// ----- rtl/ddm_pkg.sv -----
`default_nettype none

package ddm_pkg;

   // Configuration register indexes.
   typedef enum logic [1:0] {
      CSR_DEADBAND  = 2'd0,
      CSR_FULL_TURN = 2'd1,
      CSR_HOLDOFF   = 2'd2
   } csr_index_type;

   localparam int CsrIndexWidth = 2;
   localparam int CsrDataWidth  = 8;

   // Register reset values.
   localparam logic [6:0] DeadbandReset = 7'd10;
   localparam logic [6:0] FullTurnReset = 7'd80;
   localparam logic [7:0] HoldoffReset  = 8'd25;

   // Magnitude that an angle beyond the full-turn limit is forced to.
   localparam logic signed [7:0] FullTurnValue = 8'sd100;

   // Saturation limit of the holdoff counter.
   localparam logic [8:0] CountMax = 9'd511;

   typedef struct packed {
      logic signed [15:0] tilt_angle;
      logic               want_forward;
      logic [7:0]         throttle;
   } req_payload_type;

   typedef struct packed {
      logic [6:0] left_duty;
      logic [6:0] right_duty;
      logic       drive_forward;
      logic       reversing;
      logic       switched;
   } rsp_payload_type;

   // Direction status of the item that is moving to the output register.
   typedef struct packed {
      logic drive_forward;
      logic reversing;
      logic switched;
   } dir_status_type;

endpackage

`default_nettype wire

// ----- rtl/ddm_shaper.sv -----
`default_nettype none

module ddm_shaper
   import ddm_pkg::*;
(
   input  wire req_payload_type req_item,
   input  wire logic [6:0]      deadband_limit,
   input  wire logic [6:0]      full_turn_limit,
   output logic [6:0]           left_duty,
   output logic [6:0]           right_duty
);

   logic signed [16:0] angle_wide;
   logic signed [16:0] db_pos;
   logic signed [16:0] ft_pos;
   logic signed [7:0]  shaped;
   logic [7:0]         shaped_neg;
   logic [6:0]         magnitude;
   logic [6:0]         half_thr;
   logic [6:0]         inner_duty;

   // Shape the angle: deadband first, then the full-turn limit.
   always_comb begin
      angle_wide = {req_item.tilt_angle[15], req_item.tilt_angle};
      db_pos     = $signed({10'd0, deadband_limit});
      ft_pos     = $signed({10'd0, full_turn_limit});
      if ((angle_wide > -db_pos) && (angle_wide < db_pos)) begin
         shaped = 8'sd0;
      end else if (angle_wide > ft_pos) begin
         shaped = FullTurnValue;
      end else if (angle_wide < -ft_pos) begin
         shaped = -FullTurnValue;
      end else begin
         shaped = angle_wide[7:0];
      end
   end

   // The inner motor gets the halved throttle less the tilt magnitude, floored at zero.
   always_comb begin
      shaped_neg = 8'd0 - shaped;
      magnitude  = shaped[7] ? shaped_neg[6:0] : shaped[6:0];
      half_thr   = req_item.throttle[7:1];
      inner_duty = (half_thr > magnitude) ? (half_thr - magnitude) : 7'd0;
      left_duty  = half_thr;
      right_duty = half_thr;
      if (shaped < 8'sd0) begin
         left_duty = inner_duty;
      end else if (shaped > 8'sd0) begin
         right_duty = inner_duty;
      end
   end

endmodule

`default_nettype wire

// ----- rtl/ddm_holdoff.sv -----
`default_nettype none

module ddm_holdoff
   import ddm_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       advance,
   input  wire logic       want_forward,
   input  wire logic [7:0] reversal_holdoff,
   output dir_status_type  status
);

   logic       dir_ff;
   logic       dir_in;
   logic [8:0] count_ff;
   logic [8:0] count_in;

   // Hold off a reversal until the new direction has persisted long enough.
   always_comb begin
      dir_in          = dir_ff;
      count_in        = count_ff;
      status.switched = 1'b0;
      if (dir_ff != want_forward) begin
         if (count_ff > {1'b0, reversal_holdoff}) begin
            count_in        = 9'd0;
            dir_in          = want_forward;
            status.switched = 1'b1;
         end else if (count_ff < CountMax) begin
            count_in = count_ff + 9'd1;
         end
      end else begin
         count_in = 9'd0;
      end
      status.drive_forward = dir_in;
      status.reversing     = (dir_in != want_forward);
   end

   // The state moves on only when the item goes to the output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         dir_ff   <= 1'b0;
         count_ff <= 9'd0;
      end else if (advance) begin
         dir_ff   <= dir_in;
         count_ff <= count_in;
      end
   end

endmodule

`default_nettype wire

// ----- rtl/differential_drive_mixer.sv -----
// An accepted item goes through the input register, then the result register, to the rsp channel.
// Throughput: one item per cycle; the input register and the result register
// form a two-stage pipeline that stalls only when the result register is held.
// Reset (synchronous, active high) empties both stages, sets the applied
// direction to backward, clears the holdoff count and restores register defaults.
`default_nettype none

module differential_drive_mixer
   import ddm_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     csr_we,
   input  wire logic [CsrIndexWidth-1:0] csr_index,
   input  wire logic [CsrDataWidth-1:0]  csr_wdata,
   input  wire logic                     req_valid,
   output logic                          req_stall,
   input  wire req_payload_type          req_payload,
   output logic                          rsp_valid,
   input  wire logic                     rsp_stall,
   output rsp_payload_type               rsp_payload
);

   logic [6:0]      deadband_ff;
   logic [6:0]      full_turn_ff;
   logic [7:0]      holdoff_ff;
   req_payload_type item_ff;
   logic            item_valid_ff;
   rsp_payload_type rsp_ff;
   logic            rsp_valid_ff;
   rsp_payload_type rsp_in;
   logic            advance;
   logic [6:0]      left_raw;
   logic [6:0]      right_raw;
   dir_status_type  status;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         deadband_ff  <= DeadbandReset;
         full_turn_ff <= FullTurnReset;
         holdoff_ff   <= HoldoffReset;
      end else if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_DEADBAND:  deadband_ff  <= csr_wdata[6:0];
            CSR_FULL_TURN: full_turn_ff <= csr_wdata[6:0];
            CSR_HOLDOFF:   holdoff_ff   <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Pipeline flow control.
   assign advance   = item_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = item_valid_ff && rsp_valid_ff && rsp_stall;

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         item_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         item_ff <= req_payload;
      end
   end

   ddm_shaper u_shaper (
      .req_item        (item_ff),
      .deadband_limit  (deadband_ff),
      .full_turn_limit (full_turn_ff),
      .left_duty       (left_raw),
      .right_duty      (right_raw)
   );

   ddm_holdoff u_holdoff (
      .clock            (clock),
      .reset            (reset),
      .advance          (advance),
      .want_forward     (item_ff.want_forward),
      .reversal_holdoff (holdoff_ff),
      .status           (status)
   );

   // Duties read zero while a reversal is held off.
   always_comb begin
      rsp_in.left_duty     = status.reversing ? 7'd0 : left_raw;
      rsp_in.right_duty    = status.reversing ? 7'd0 : right_raw;
      rsp_in.drive_forward = status.drive_forward;
      rsp_in.reversing     = status.reversing;
      rsp_in.switched      = status.switched;
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (!rsp_valid_ff || !rsp_stall) begin
         rsp_valid_ff <= item_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

`default_nettype wire
